// ===== src/fvspm_pkg.sv =====
`timescale 1ns / 1ps

package fvspm_pkg;

    localparam int VOICE_COUNT_DEF  = 4;
    localparam int SAMPLE_DEPTH_DEF = 8192;

    localparam int CMD_W     = 2;
    localparam int VOICE_W   = 2;
    localparam int ADDR_W    = 13;
    localparam int SAMPLE_W  = 8;
    localparam int MASK_W    = 4;
    localparam int LEN_W     = 14;
    localparam int LEN_REGS  = 4;
    localparam int CFG_IDX_W = 3;

    localparam int MIX_MAX = 127;
    localparam int MIX_MIN = -128;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_TRIG   = 2'd1,
        CMD_RETRIG = 2'd2,
        CMD_LOAD   = 2'd3
    } t_cmd;

endpackage

// ===== src/fvspm_ifs.sv =====
`timescale 1ns / 1ps

interface fvspm_in_if import fvspm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [VOICE_W-1:0]         voice;
    logic [ADDR_W-1:0]          load_address;
    logic signed [SAMPLE_W-1:0] load_value;

    modport source (output valid, cmd, voice, load_address, load_value, input ready);
    modport sink   (input valid, cmd, voice, load_address, load_value, output ready);
endinterface

interface fvspm_out_if import fvspm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic [MASK_W-1:0]          playing_mask;
    logic [VOICE_W-1:0]         last_voice;

    modport source (output valid, mixed_sample, playing_mask, last_voice, input ready);
    modport sink   (input valid, mixed_sample, playing_mask, last_voice, output ready);
endinterface

interface fvspm_cfg_if import fvspm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [LEN_W-1:0]     write_data;

    modport source (output valid, reg_index, write_data, input ready);
    modport sink   (input valid, reg_index, write_data, output ready);
endinterface

// ===== src/four_voice_sample_player_mixer.sv =====
`timescale 1ns / 1ps
// channel  | dir | beat contents                                  | notes
// i_in     | in  | cmd, voice, load_address, load_value           | tick/trigger/retrigger/load
// o_out    | out | mixed_sample, playing_mask, last_voice         | one beat per tick
// i_cfg    | in  | reg_index, write_data                          | voice length registers
//
// trigger, retrigger and load are each taken back to back
// a tick makes one sample memory read per voice, in turn
// through the single read port, then adds the last read and clamps
// the result sits in an output register; the next beat is taken while it waits
// synchronous active-low reset clears voice state, lengths and the output valid

module four_voice_sample_player_mixer
    import fvspm_pkg::*;
#(
    parameter int VOICE_COUNT  = VOICE_COUNT_DEF,
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fvspm_in_if.sink     i_in,
    fvspm_out_if.source  o_out,
    fvspm_cfg_if.sink    i_cfg
);

    localparam int VIDX_W    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int POS_W     = $clog2(SAMPLE_DEPTH + 1);
    localparam int MEM_DEPTH = VOICE_COUNT * SAMPLE_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int SUM_W     = SAMPLE_W + 1 + $clog2(VOICE_COUNT);

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(MIX_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(MIX_MIN);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_LAST, S_HOLD} t_state;

    t_state r_state;

    logic [LEN_W-1:0]    r_len [LEN_REGS];
    logic [POS_W-1:0]    r_pos [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] r_playing;
    logic [VOICE_W-1:0]  r_last;

    logic [SAMPLE_W-1:0] r_mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_hit;

    logic [VIDX_W-1:0]      r_idx;
    logic signed [SUM_W-1:0] r_acc;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_mixed;
    logic [MASK_W-1:0]          r_mask;
    logic [VOICE_W-1:0]         r_last_out;

    logic in_acc;
    logic tick_acc;
    logic trig_ok;
    logic load_ok;
    logic step_en;
    logic [VIDX_W-1:0] step_idx;
    logic [POS_W-1:0]  cur_pos;
    logic              cur_play;
    logic [LEN_W-1:0]  cur_len;
    logic              hit;
    logic [MEM_AW-1:0] rd_addr;
    logic [MEM_AW-1:0] wr_addr;
    logic signed [SUM_W-1:0] contrib;
    logic signed [SUM_W-1:0] sum_next;
    logic [MASK_W-1:0] mask_now;
    logic              out_free;
    logic              out_load;

    function automatic logic signed [SAMPLE_W-1:0] clamp(input logic signed [SUM_W-1:0] s);
        logic signed [SAMPLE_W-1:0] c;
        if (s > SUM_MAX) begin
            c = SAMPLE_W'(MIX_MAX);
        end else if (s < SUM_MIN) begin
            c = SAMPLE_W'(MIX_MIN);
        end else begin
            c = s[SAMPLE_W-1:0];
        end
        return c;
    endfunction

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign in_acc   = i_in.valid && i_in.ready;
    assign tick_acc = in_acc && (t_cmd'(i_in.cmd) == CMD_TICK);
    assign trig_ok  = 32'(i_in.voice) < VOICE_COUNT;
    assign load_ok  = trig_ok && (32'(i_in.load_address) < SAMPLE_DEPTH);

    assign step_en  = tick_acc || (r_state == S_WALK);
    assign step_idx = (r_state == S_IDLE) ? '0 : r_idx;

    always_comb begin
        cur_pos  = '0;
        cur_play = 1'b0;
        cur_len  = '0;
        for (int j = 0; j < VOICE_COUNT; j++) begin
            if (32'(step_idx) == j) begin
                cur_pos  = r_pos[j];
                cur_play = r_playing[j];
            end
        end
        for (int j = 0; j < LEN_REGS; j++) begin
            if (32'(step_idx) == j) begin
                cur_len = r_len[j];
            end
        end
    end

    assign hit = cur_play && (32'(cur_pos) < 32'(cur_len)) && (32'(cur_pos) < SAMPLE_DEPTH);
    assign rd_addr = MEM_AW'(step_idx) * MEM_AW'(SAMPLE_DEPTH) + MEM_AW'(cur_pos);
    assign wr_addr = MEM_AW'(i_in.voice) * MEM_AW'(SAMPLE_DEPTH) + MEM_AW'(i_in.load_address);

    assign contrib  = r_hit ? SUM_W'($signed(r_rd_data)) : '0;
    assign sum_next = r_acc + contrib;
    assign out_free = !r_out_valid || o_out.ready;
    assign out_load = ((r_state == S_LAST) || (r_state == S_HOLD)) && out_free;

    always_comb begin
        mask_now = '0;
        for (int j = 0; j < MASK_W; j++) begin
            if (j < VOICE_COUNT) begin
                mask_now[j] = r_playing[j];
            end
        end
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if (in_acc && (t_cmd'(i_in.cmd) == CMD_LOAD) && load_ok) begin
            r_mem[wr_addr] <= i_in.load_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // length registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LEN_REGS; j++) begin
                r_len[j] <= '0;
            end
        end else if (i_cfg.valid && i_cfg.ready) begin
            for (int j = 0; j < LEN_REGS; j++) begin
                if (32'(i_cfg.reg_index) == j) begin
                    r_len[j] <= i_cfg.write_data;
                end
            end
        end
    end

    // per-voice play state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < VOICE_COUNT; j++) begin
                r_pos[j] <= '0;
            end
            r_playing <= '0;
            r_last    <= '0;
            r_hit     <= 1'b0;
        end else begin
            r_hit <= step_en && hit;
            for (int j = 0; j < VOICE_COUNT; j++) begin
                if (step_en && (32'(step_idx) == j)) begin
                    if (hit) begin
                        r_pos[j] <= r_pos[j] + POS_W'(1);
                    end else begin
                        r_playing[j] <= 1'b0;
                    end
                end
                if (in_acc && (t_cmd'(i_in.cmd) == CMD_TRIG) && (32'(i_in.voice) == j)) begin
                    r_pos[j]     <= '0;
                    r_playing[j] <= 1'b1;
                end
                if (in_acc && (t_cmd'(i_in.cmd) == CMD_RETRIG) && (32'(r_last) == j)) begin
                    r_pos[j]     <= '0;
                    r_playing[j] <= 1'b1;
                end
            end
            if (in_acc && (t_cmd'(i_in.cmd) == CMD_TRIG) && trig_ok) begin
                r_last <= i_in.voice;
            end
        end
    end

    // tick sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (tick_acc) begin
                        r_acc   <= '0;
                        r_idx   <= VIDX_W'(1);
                        r_state <= (VOICE_COUNT == 1) ? S_LAST : S_WALK;
                    end
                end
                S_WALK: begin
                    r_acc <= sum_next;
                    if (32'(r_idx) == VOICE_COUNT - 1) begin
                        r_state <= S_LAST;
                    end else begin
                        r_idx <= r_idx + VIDX_W'(1);
                    end
                end
                S_LAST: begin
                    r_acc <= sum_next;
                    if (out_free) begin
                        r_mixed     <= clamp(sum_next);
                        r_mask      <= mask_now;
                        r_last_out  <= r_last;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_mixed     <= clamp(r_acc);
                        r_mask      <= mask_now;
                        r_last_out  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.mixed_sample = r_mixed;
    assign o_out.playing_mask = r_mask;
    assign o_out.last_voice   = r_last_out;

    a_tick_blocks_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> !i_in.ready)
        else $error("input taken during tick walk");

    a_out_from_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_LAST || $past(r_state) == S_HOLD))
        else $error("result raised outside tick tail");

    a_hit_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> $past(step_en))
        else $error("sample read without a voice step");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing[0] |-> (32'(r_pos[0]) <= SAMPLE_DEPTH))
        else $error("voice 0 position past memory depth");

endmodule

// ===== tb/sv/tb_four_voice_sample_player_mixer.sv =====
`timescale 1ns / 1ps

module tb_four_voice_sample_player_mixer;
    import fvspm_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RST_CYCLES    = 9;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_BEATS   = 120;
    localparam int DEPTH_TICKS   = 24;
    localparam int NUM_IDX       = 1 << CFG_IDX_W;
    localparam int REG_LEN_BASE  = 0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed;
        logic [MASK_W-1:0]          mask;
        logic [VOICE_W-1:0]         last;
    } t_mix_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #(CLK_HALF) i_clk = ~i_clk;

    fvspm_in_if  in_if ();
    fvspm_out_if out_if ();
    fvspm_cfg_if cfg_if ();

    four_voice_sample_player_mixer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // mixer state as the block should hold it
    logic [LEN_W-1:0]           len_reg    [LEN_REGS];
    logic signed [SAMPLE_W-1:0] sample_mem [VOICE_COUNT_DEF][SAMPLE_DEPTH_DEF];
    bit                         loaded     [VOICE_COUNT_DEF][SAMPLE_DEPTH_DEF];
    int unsigned                play_pos   [VOICE_COUNT_DEF];
    bit                         playing    [VOICE_COUNT_DEF];
    logic [VOICE_W-1:0]         last_trig;

    t_mix_result mix_expected [$];

    int fail_count;
    int n_items;
    int n_checked;
    int n_clamped;
    int n_trig;
    int n_loads;

    int burst_left;
    int gap_max;
    bit stall_on;
    logic [15:0] stall_pattern;
    int stall_phase;

    function automatic int unsigned active_length(int v);
        int unsigned l;
        l = len_reg[v];
        if (l > SAMPLE_DEPTH_DEF) begin
            l = SAMPLE_DEPTH_DEF;
        end
        return l;
    endfunction

    function automatic void model_beat(t_cmd cmd, logic [VOICE_W-1:0] voice,
                                       logic [ADDR_W-1:0] addr,
                                       logic signed [SAMPLE_W-1:0] value);
        int sum;
        t_mix_result r;
        case (cmd)
            CMD_TRIG: begin
                playing[voice]  = 1'b1;
                play_pos[voice] = 0;
                last_trig       = voice;
                n_trig++;
            end
            CMD_RETRIG: begin
                playing[last_trig]  = 1'b1;
                play_pos[last_trig] = 0;
            end
            CMD_LOAD: begin
                sample_mem[voice][addr] = value;
                loaded[voice][addr]     = 1'b1;
                n_loads++;
            end
            CMD_TICK: begin
                sum = 0;
                for (int v = 0; v < VOICE_COUNT_DEF; v++) begin
                    if (playing[v]) begin
                        if (play_pos[v] < active_length(v)) begin
                            sum += sample_mem[v][play_pos[v]];
                            play_pos[v]++;
                        end else begin
                            playing[v] = 1'b0;
                        end
                    end
                end
                for (int v = 0; v < MASK_W; v++) begin
                    r.mask[v] = playing[v];
                end
                if (sum > MIX_MAX) begin
                    sum = MIX_MAX;
                    n_clamped++;
                end else if (sum < MIX_MIN) begin
                    sum = MIX_MIN;
                    n_clamped++;
                end
                r.mixed = SAMPLE_W'(sum);
                r.last  = last_trig;
                mix_expected.push_back(r);
            end
        endcase
    endfunction

    task automatic send_beat(t_cmd cmd, logic [VOICE_W-1:0] voice,
                             logic [ADDR_W-1:0] addr, logic signed [SAMPLE_W-1:0] value);
        int gap;
        if (gap_max > 0 && burst_left == 0) begin
            gap        = $urandom_range(1, gap_max);
            burst_left = $urandom_range(1, 16);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        in_if.valid        <= 1'b1;
        in_if.cmd          <= cmd;
        in_if.voice        <= voice;
        in_if.load_address <= addr;
        in_if.load_value   <= value;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        model_beat(cmd, voice, addr, value);
        n_items++;
    endtask

    // fill any sample the tick is about to read
    task automatic send_tick();
        for (int v = 0; v < VOICE_COUNT_DEF; v++) begin
            if (playing[v] && play_pos[v] < active_length(v) && !loaded[v][play_pos[v]]) begin
                send_beat(CMD_LOAD, VOICE_W'(v), ADDR_W'(play_pos[v]), SAMPLE_W'($urandom));
            end
        end
        send_beat(CMD_TICK, VOICE_W'($urandom), ADDR_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic write_reg(int idx, logic [LEN_W-1:0] data);
        cfg_if.valid      <= 1'b1;
        cfg_if.reg_index  <= CFG_IDX_W'(idx);
        cfg_if.write_data <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        if (idx < LEN_REGS) begin
            len_reg[idx] = data;
        end
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (mix_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return LEN_W'($urandom_range(1, 24));
        end else if (r == 6) begin
            return '0;
        end else if (r == 7) begin
            return LEN_W'(SAMPLE_DEPTH_DEF);
        end else if (r == 8) begin
            return '1;
        end
        return LEN_W'($urandom);
    endfunction

    function automatic void check_beat();
        t_mix_result got;
        t_mix_result want;
        got = '{out_if.mixed_sample, out_if.playing_mask, out_if.last_voice};
        if (mix_expected.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
                $display("unexpected mix beat: sample %0d mask %b last %0d",
                         got.mixed, got.mask, got.last);
            end
            return;
        end
        want = mix_expected.pop_front();
        n_checked++;
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
                $display("mix beat %0d: expected sample %0d mask %b last %0d, got %0d %b %0d",
                         n_checked, want.mixed, want.mask, want.last,
                         got.mixed, got.mask, got.last);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_phase = 0;
        end else begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                check_beat();
            end
            if (stall_phase == 0) begin
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            end
            out_if.ready <= !stall_on || stall_pattern[stall_phase];
            stall_phase = (stall_phase + 1) % 16;
        end
    end

    task automatic test_idle_and_zero_length();
        gap_max  = 0;
        stall_on = 1'b0;
        send_tick();
        send_tick();
        send_beat(CMD_TRIG, 2'd2, '0, '0);
        send_tick();
        send_beat(CMD_RETRIG, 2'd0, '0, '0);
        send_tick();
        send_tick();
        drain();
    endtask

    task automatic test_mix_clamp();
        for (int v = 0; v < LEN_REGS; v++) begin
            write_reg(REG_LEN_BASE + v, LEN_W'(3));
        end
        gap_max  = 3;
        stall_on = 1'b1;
        for (int v = 0; v < VOICE_COUNT_DEF; v++) begin
            send_beat(CMD_LOAD, VOICE_W'(v), ADDR_W'(0), SAMPLE_W'(MIX_MAX));
            send_beat(CMD_LOAD, VOICE_W'(v), ADDR_W'(1), SAMPLE_W'(MIX_MIN));
        end
        send_beat(CMD_LOAD, 2'd0, ADDR_W'(2), 8'sd100);
        send_beat(CMD_LOAD, 2'd1, ADDR_W'(2), -8'sd50);
        send_beat(CMD_LOAD, 2'd2, ADDR_W'(2), 8'sd20);
        send_beat(CMD_LOAD, 2'd3, ADDR_W'(2), -8'sd1);
        send_beat(CMD_LOAD, 2'd3, '1, '1);
        for (int v = 0; v < VOICE_COUNT_DEF; v++) begin
            send_beat(CMD_TRIG, VOICE_W'(v), '0, '0);
        end
        repeat (4) send_tick();
        send_beat(CMD_RETRIG, 2'd1, '0, '0);
        repeat (4) send_tick();
        drain();
    endtask

    task automatic test_unused_registers();
        for (int i = LEN_REGS; i < NUM_IDX; i++) begin
            write_reg(i, '1);
        end
        write_reg(REG_LEN_BASE + 1, LEN_W'(2));
        gap_max  = 4;
        stall_on = 1'b1;
        send_beat(CMD_TRIG, 2'd1, '0, '0);
        send_beat(CMD_TRIG, 2'd0, '0, '0);
        repeat (4) send_tick();
        drain();
    endtask

    // lengths at and above depth play next to a one-sample voice
    task automatic test_depth_limit();
        write_reg(REG_LEN_BASE + 0, '0);
        write_reg(REG_LEN_BASE + 1, LEN_W'(1));
        write_reg(REG_LEN_BASE + 2, LEN_W'(SAMPLE_DEPTH_DEF));
        write_reg(REG_LEN_BASE + 3, '1);
        gap_max  = 2;
        stall_on = 1'b0;
        send_beat(CMD_TRIG, 2'd2, '0, '0);
        send_beat(CMD_TRIG, 2'd3, '0, '0);
        send_beat(CMD_TRIG, 2'd1, '0, '0);
        for (int k = 0; k < DEPTH_TICKS; k++) begin
            send_tick();
            if (k == DEPTH_TICKS / 2) begin
                stall_on = 1'b1;
            end
        end
        send_beat(CMD_RETRIG, 2'd0, '0, '0);
        repeat (4) send_tick();
        drain();
    endtask

    task automatic random_beat();
        int pick;
        logic [VOICE_W-1:0] v;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        v    = VOICE_W'($urandom);
        a    = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(0, 31));
        if (pick < 50) begin
            send_tick();
        end else if (pick < 65) begin
            send_beat(CMD_TRIG, v, a, SAMPLE_W'($urandom));
        end else if (pick < 75) begin
            send_beat(CMD_RETRIG, v, a, SAMPLE_W'($urandom));
        end else begin
            send_beat(CMD_LOAD, v, a, SAMPLE_W'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (int v = 0; v < LEN_REGS; v++) begin
                write_reg(REG_LEN_BASE + v, pick_length());
            end
            gap_max  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            stall_on = $urandom_range(0, 1);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                random_beat();
            end
            drain();
        end
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.cmd          <= CMD_TICK;
        in_if.voice        <= '0;
        in_if.load_address <= '0;
        in_if.load_value   <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.reg_index   <= '0;
        cfg_if.write_data  <= '0;
        foreach (len_reg[i]) begin
            len_reg[i] = '0;
        end
        last_trig  = '0;
        fail_count = 0;
        burst_left = 0;
        gap_max    = 0;
        stall_on   = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_zero_length();
        test_mix_clamp();
        test_unused_registers();
        test_depth_limit();
        test_random_traffic();
        drain();

        if (mix_expected.size() != 0) begin
            $display("%0d mix beats never arrived", mix_expected.size());
            fail_count += mix_expected.size();
        end
        $display("%0d input beats (%0d loads, %0d triggers), %0d mix beats checked, %0d clamped",
                 n_items, n_loads, n_trig, n_checked, n_clamped);
        $display("lengths from zero to above depth, unused register indexes, %0d failures",
                 fail_count);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/fvspm_pkg.sv
src/fvspm_ifs.sv
src/four_voice_sample_player_mixer.sv
tb/sv/tb_four_voice_sample_player_mixer.sv
